// ===== src/bounded_list_insert_remove_top_macros.svh =====
// Assertion macros for the bounded list RTL, used by the request sequencer.
`ifndef BOUNDED_LIST_INSERT_REMOVE_TOP_MACROS_SVH
`define BOUNDED_LIST_INSERT_REMOVE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BLI_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLI_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/bli_pkg.sv =====
// Types, codes and helpers shared by the bounded list modules.
package bli_pkg;

   localparam int ENTRIES_W = 5;
   localparam int TALLY_W   = 16;
   localparam int VALUE_W   = 32;

   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_REMOVED   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [ENTRIES_W-1:0] entries_held;
      logic [TALLY_W-1:0]   inserts_total;
      logic [TALLY_W-1:0]   removals_total;
   } rsp_type;

   function automatic logic [TALLY_W-1:0] bump_tally(input logic [TALLY_W-1:0] t);
      bump_tally = (t == TALLY_MAX) ? t : t + 1'b1;
   endfunction

endpackage

// ===== src/bounded_list_insert_remove_top.sv =====
// Top level of the bounded list with append and compacting remove.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/stall    req_data  (bli_pkg::req_type)
//   rsp_      out        rsp_valid/stall    rsp_data  (bli_pkg::rsp_type)
//
// An insert's response goes through the sequencer's done state and then the output register.
// A remove scans the filled entries through the single read port of the slot memory, one
// per cycle, and the compacting shift streams on from the match through the same port
// while writing one entry down per cycle. Its response goes through the done state and
// then the output register once the scan, and on a match the shift, has ended.
// Reset is synchronous and clears the occupancy, the tallies and all handshake state;
// the slot memory is not cleared, and only filled entries are ever read.
// A new request is accepted while an earlier response still waits under rsp_stall; the
// sequencer then holds its finished response until the output register frees.
module bounded_list_insert_remove_top import bli_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   localparam int IW = $clog2(SLOTS);

   // Memory port signals between the sequencer and the slot memory.
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // Finished response from the sequencer and the output register state.
   logic    done;
   rsp_type result;
   logic    out_free;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   bli_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   bli_slot_ram #(
      .SLOTS (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The output register can take a new response when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/bli_slot_ram.sv =====
// Slot memory: one write port and one read port with registered read data.
module bli_slot_ram import bli_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int IW    = $clog2(SLOTS)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [IW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [SLOTS];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bli_ctrl.sv =====
// Request sequencer: append, search scan, compacting shift and tallies.
`include "bounded_list_insert_remove_top_macros.svh"
module bli_ctrl import bli_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int IW    = $clog2(SLOTS),
   parameter int CW    = $clog2(SLOTS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  req_type            req_data,
   output logic               req_stall,
   input  logic               out_free,
   output logic               done,
   output rsp_type            result,
   output logic               wr_en,
   output logic [IW-1:0]      wr_addr,
   output logic [VALUE_W-1:0] wr_data,
   output logic               rd_en,
   output logic [IW-1:0]      rd_addr,
   input  logic [VALUE_W-1:0] rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_DONE
   } state_type;

   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

   state_type          state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [TALLY_W-1:0] ins_ff, ins_in;
   logic [TALLY_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic               dvalid_ff, dvalid_in;
   logic [IW-1:0]      daddr_ff, daddr_in;
   status_type         status_ff, status_in;
   logic               issue;
   logic [CW+ENTRIES_W-1:0] fill_wide;

   // A read is issued each cycle while unread filled entries remain.
   assign issue = (rd_ptr_ff < fill_ff);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      ins_in    = ins_ff;
      rem_in    = rem_ff;
      value_in  = value_ff;
      rd_ptr_in = rd_ptr_ff;
      dvalid_in = dvalid_ff;
      daddr_in  = daddr_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = daddr_ff - 1'b1;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = rd_ptr_ff[IW-1:0];
      done      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in  = req_data.item_value;
               rd_ptr_in = '0;
               dvalid_in = 1'b0;
               if (req_data.operation == OP_INSERT) begin
                  if (fill_ff < SLOTS_C) begin
                     wr_en     = 1'b1;
                     wr_addr   = fill_ff[IW-1:0];
                     wr_data   = req_data.item_value;
                     fill_in   = fill_ff + 1'b1;
                     ins_in    = bump_tally(ins_ff);
                     status_in = ST_INSERTED;
                  end else begin
                     status_in = ST_FULL;
                  end
                  state_in = S_DONE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            rd_en     = issue;
            dvalid_in = issue;
            daddr_in  = rd_ptr_ff[IW-1:0];
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            if (dvalid_ff && (rd_data == value_ff)) begin
               state_in = S_SHIFT;
            end else if (!dvalid_ff && !issue) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_SHIFT: begin
            rd_en     = issue;
            dvalid_in = issue;
            daddr_in  = rd_ptr_ff[IW-1:0];
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            if (dvalid_ff) begin
               // Entry read last cycle moves down one place.
               wr_en = 1'b1;
            end else begin
               fill_in   = fill_ff - 1'b1;
               rem_in    = bump_tally(rem_ff);
               status_in = ST_REMOVED;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            done = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         ins_ff    <= '0;
         rem_ff    <= '0;
         rd_ptr_ff <= '0;
         dvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         ins_ff    <= ins_in;
         rem_ff    <= rem_in;
         rd_ptr_ff <= rd_ptr_in;
         dvalid_ff <= dvalid_in;
      end
      value_ff  <= value_in;
      daddr_ff  <= daddr_in;
      status_ff <= status_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   assign fill_wide             = {{ENTRIES_W{1'b0}}, fill_ff};
   assign result.status         = status_ff;
   assign result.entries_held   = fill_wide[ENTRIES_W-1:0];
   assign result.inserts_total  = ins_ff;
   assign result.removals_total = rem_ff;

   `BLI_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= SLOTS_C, "fill count exceeds slots")
   `BLI_ASSERT_NOW(a_shift_below_fill, clock, reset, (state_ff == S_SHIFT) && wr_en, {1'b0, wr_addr} < fill_ff, "shift writes past the filled entries")
   `BLI_ASSERT_NEXT(a_remove_drops_one, clock, reset, (state_ff == S_SHIFT) && !dvalid_ff, fill_ff == $past(fill_ff) - 1'b1, "removal did not drop one entry")
   `BLI_ASSERT_NOW(a_write_in_idle_is_insert, clock, reset, wr_en && (state_ff == S_IDLE), req_valid && (req_data.operation == OP_INSERT), "stray memory write")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the bounded list with append and compacting remove.
module tb_top;
   import bli_pkg::*;

   // The list depth is set here and passed to the block, so the predictor and the RTL
   // always agree on when the list is full.
   localparam int LIST_DEPTH    = 16;
   localparam int RANDOM_CMDS   = 910;
   // The last stretch of random commands runs with no idling on either side.
   localparam int TAIL_CMDS     = 150;
   // The slowest request is a remove from a full list. Add to it the longest stall and
   // the longest sender gap, then allow a wide margin.
   localparam int HANG_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = LIST_DEPTH + 12;
   localparam int MAX_REPORTS   = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   bounded_list_insert_remove_top #(.SLOTS(LIST_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   always #4 clock = ~clock;

   // Commands waiting to be sent, and the results owed for commands already accepted.
   req_type list_cmds_queued[$];
   rsp_type list_results_due[$];

   // Our own copy of the list contents, its occupancy and the two tallies.
   logic [VALUE_W-1:0] shadow_slots [LIST_DEPTH];
   int                 shadow_fill   = 0;
   logic [TALLY_W-1:0] shadow_ins    = '0;
   logic [TALLY_W-1:0] shadow_rem    = '0;
   int                 status_seen [4];

   int cmds_accepted  = 0;
   int results_seen   = 0;
   int mismatch_count = 0;

   // When set, neither side inserts idle cycles; used for the last part of the run.
   bit idle_off = 1'b0;

   // Apply one command to the shadow list and return the result the block must give.
   // An insert lands at the end unless the list is full. A remove takes out the first
   // matching entry only and closes the hole by moving every later entry down one place.
   function automatic rsp_type predict_list_op(input req_type cmd);
      rsp_type res;
      int      hit_pos;
      hit_pos = -1;
      if (cmd.operation == OP_INSERT) begin
         if (shadow_fill >= LIST_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            shadow_slots[shadow_fill] = cmd.item_value;
            shadow_fill++;
            if (shadow_ins != TALLY_MAX) begin
               shadow_ins++;
            end
            res.status = ST_INSERTED;
         end
      end else begin
         for (int i = 0; i < shadow_fill; i++) begin
            if (hit_pos < 0 && shadow_slots[i] == cmd.item_value) begin
               hit_pos = i;
            end
         end
         if (hit_pos >= 0) begin
            for (int i = hit_pos; i + 1 < shadow_fill; i++) begin
               shadow_slots[i] = shadow_slots[i + 1];
            end
            shadow_fill--;
            if (shadow_rem != TALLY_MAX) begin
               shadow_rem++;
            end
            res.status = ST_REMOVED;
         end else begin
            res.status = ST_NOT_FOUND;
         end
      end
      res.entries_held   = ENTRIES_W'(shadow_fill);
      res.inserts_total  = shadow_ins;
      res.removals_total = shadow_rem;
      status_seen[res.status]++;
      return res;
   endfunction

   // Every failure goes through here. Only the first few are printed, but all are counted.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("MISMATCH at result %0d: %s, got %0h, expected %0h",
                  results_seen, what, got, want);
      end
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      if (got.status !== want.status) begin
         report_mismatch("status", 32'(got.status), 32'(want.status));
      end
      if (got.entries_held !== want.entries_held) begin
         report_mismatch("entries_held", 32'(got.entries_held), 32'(want.entries_held));
      end
      if (got.inserts_total !== want.inserts_total) begin
         report_mismatch("inserts_total", 32'(got.inserts_total), 32'(want.inserts_total));
      end
      if (got.removals_total !== want.removals_total) begin
         report_mismatch("removals_total", 32'(got.removals_total),
                         32'(want.removals_total));
      end
   endtask

   task automatic queue_cmd(input op_type op, input logic [VALUE_W-1:0] value);
      req_type cmd;
      cmd.operation  = op;
      cmd.item_value = value;
      list_cmds_queued.push_back(cmd);
   endtask

   // Request driver. A request is taken when valid is high and stall is low at the edge;
   // the prediction is made right then, so the owed results stay in acceptance order.
   // A stalled request is held unchanged. After an accepted request the sender sometimes
   // goes quiet for a burst of random length, and now and then it switches into a stretch
   // with no gaps at all.
   int sender_gap   = 0;
   bit sender_quiet = 1'b0;

   always @(posedge clock) begin
      bit took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            list_results_due.push_back(predict_list_op(req_data));
            cmds_accepted++;
            if ($urandom_range(0, 63) == 0) begin
               sender_quiet = !sender_quiet;
            end
            if (!idle_off && !sender_quiet && $urandom_range(0, 3) == 0) begin
               sender_gap = $urandom_range(1, 9);
            end
         end
         if (req_valid && !took) begin
            // Still stalled: the request stays on the bus as it is.
         end else if (sender_gap > 0) begin
            sender_gap--;
            req_valid <= 1'b0;
         end else if (list_cmds_queued.size() > 0) begin
            req_data  <= list_cmds_queued.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor. Each accepted result is checked against the oldest owed result.
   // The receiver stalls in bursts of random length, with quiet stretches in between.
   int receiver_stall = 0;
   bit receiver_quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (list_results_due.size() == 0) begin
               report_mismatch("result with no request outstanding",
                               32'(rsp_data.status), '0);
            end else begin
               check_result(rsp_data, list_results_due.pop_front());
            end
            if ($urandom_range(0, 63) == 0) begin
               receiver_quiet = !receiver_quiet;
            end
         end
         if (receiver_stall > 0) begin
            receiver_stall--;
            rsp_stall <= 1'b1;
         end else if (!idle_off && !receiver_quiet && $urandom_range(0, 9) == 0) begin
            receiver_stall = $urandom_range(1, 9) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Hang detection. Sampled on the falling edge so that all updates of the rising edge
   // have settled. Only cycles with work outstanding and no handshake on either side count.
   int hang_cycles   = 0;
   int last_progress = 0;

   always @(negedge clock) begin
      if (reset || (cmds_accepted + results_seen) != last_progress ||
          (list_cmds_queued.size() == 0 && !req_valid && list_results_due.size() == 0)) begin
         hang_cycles   = 0;
         last_progress = cmds_accepted + results_seen;
      end else begin
         hang_cycles++;
         if (hang_cycles >= HANG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Waits on the falling edge until every queued command has been sent and answered.
   task automatic wait_for_idle();
      while (list_cmds_queued.size() > 0 || req_valid || list_results_due.size() > 0) begin
         @(negedge clock);
      end
   endtask

   logic [VALUE_W-1:0] common_vals [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                           32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA};

   initial begin
      logic [VALUE_W-1:0] recent_vals[$];
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] last_fill_val;
      int                 insert_pct;
      int                 drain_count;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. A remove from the empty list finds nothing. Then the value
      // extremes go in, with a duplicate of zero, and two removes of zero take out the
      // first copy and then the second. A remove of an absent value reports not found.
      queue_cmd(OP_REMOVE, 32'h0000_0000);
      queue_cmd(OP_INSERT, 32'h0000_0000);
      queue_cmd(OP_INSERT, 32'hFFFF_FFFF);
      queue_cmd(OP_INSERT, 32'hA5A5_A5A5);
      queue_cmd(OP_INSERT, 32'h0000_0000);
      queue_cmd(OP_REMOVE, 32'h0000_0000);
      queue_cmd(OP_REMOVE, 32'h0000_0000);
      queue_cmd(OP_REMOVE, 32'h1234_5678);
      // Fill the list to the top, try one insert too many, then remove the head entry,
      // which shifts the whole list, and the tail entry, which shifts nothing.
      last_fill_val = '0;
      for (int i = 0; i < LIST_DEPTH - 2; i++) begin
         last_fill_val = 32'h0123_4567 ^ (32'h1111_1111 * (i + 1));
         queue_cmd(OP_INSERT, last_fill_val);
      end
      queue_cmd(OP_INSERT, 32'h8000_0000);
      queue_cmd(OP_REMOVE, 32'hFFFF_FFFF);
      queue_cmd(OP_REMOVE, last_fill_val);
      queue_cmd(OP_INSERT, 32'h7FFF_FFFF);

      // Random part. The insert share changes every 50 commands so the list swings
      // between empty and full. Most removes name a recently inserted value so they
      // find something; a small set of common values makes duplicates likely.
      insert_pct = 50;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n == RANDOM_CMDS - TAIL_CMDS) begin
            // From here on neither side idles.
            wait_for_idle();
            idle_off = 1'b1;
         end
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  insert_pct = 85;
               end
               1: begin
                  insert_pct = 50;
               end
               default: begin
                  insert_pct = 15;
               end
            endcase
         end
         if ($urandom_range(1, 100) <= insert_pct) begin
            if ($urandom_range(0, 2) == 0) begin
               value = common_vals[$urandom_range(0, 5)];
            end else begin
               value = $urandom;
            end
            queue_cmd(OP_INSERT, value);
            recent_vals.push_back(value);
            if (recent_vals.size() > 24) begin
               void'(recent_vals.pop_front());
            end
         end else begin
            if (recent_vals.size() > 0 && $urandom_range(0, 9) < 7) begin
               value = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
            end else if ($urandom_range(0, 1) == 0) begin
               value = common_vals[$urandom_range(0, 5)];
            end else begin
               value = $urandom;
            end
            queue_cmd(OP_REMOVE, value);
         end
      end
      wait_for_idle();

      // Empty the list by removing its entries in order; each one is then the head, so
      // every remove hits.
      drain_count = shadow_fill;
      for (int i = 0; i < drain_count; i++) begin
         queue_cmd(OP_REMOVE, shadow_slots[i]);
      end
      wait_for_idle();

      // Let any stray result show up before the verdict.
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (list_results_due.size() > 0) begin
         report_mismatch("results never arrived", list_results_due.size(), 0);
      end

      $display("Ran %0d requests and checked %0d results: %0d inserted, %0d refused full,",
               cmds_accepted, results_seen, status_seen[ST_INSERTED], status_seen[ST_FULL]);
      $display("%0d removed, %0d not found; tallies ended at %0d inserts, %0d removals.",
               status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND], shadow_ins, shadow_rem);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/bli_pkg.sv
src/bli_slot_ram.sv
src/bli_ctrl.sv
src/bounded_list_insert_remove_top.sv
verif/tb_top.sv
